>>> rtl/core/rcab_pkg.sv
// ----------------------------------------------------------------------------
// rcab_pkg
// Shared types and constants of the range checked allocation bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

package rcab_pkg;

	localparam int MAP_BITS  = 8192;
	localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
	localparam int OFF_W     = $clog2(MAP_BITS);
	localparam int ADDR_W    = $clog2(MAP_BYTES);
	localparam int IDX_W     = 32;
	localparam int LEN_W     = 14;
	localparam int CFG_IDX_W = 1;

	localparam logic [2:0]       BIT_IN_BYTE = 3'h7;
	localparam logic [IDX_W-1:0] LIMIT_MAX   = IDX_W'(MAP_BITS - 1);

	localparam logic [IDX_W-1:0] FIRST_RESET = 32'd0;
	localparam logic [IDX_W-1:0] LAST_RESET  = 32'd8191;

	typedef enum logic [1:0] {
		MODE_MARK   = 2'd0,
		MODE_UNMARK = 2'd1,
		MODE_TEST   = 2'd2,
		MODE_RUN    = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_INDEX = 1'd0,
		CFG_LAST_INDEX  = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		mode_t              mode;
		logic [IDX_W-1:0]   object_number;
		logic [LEN_W-1:0]   run_length;
	} in_item_t;

	typedef struct packed {
		logic answer;
		logic out_of_range;
	} out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/rcab_ram.sv
// ----------------------------------------------------------------------------
// rcab_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/range_checked_allocation_bitmap.sv
// ----------------------------------------------------------------------------
// range_checked_allocation_bitmap
// Bit-per-object allocation map with a window check on every access.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid / in_stall, in_item): one request per item, mode
//   mark, unmark, test one bit or test a run of bits for all free.
//   out channel (out_valid / out_stall, out_item): one result per request,
//   in request order. cfg channel (cfg_valid / cfg_ready): writes the window
//   registers, always ready; write only while no request is in flight.
//   One request is worked on at a time. Mark, unmark and test go through
//   the window check, then the map byte read and write back, then back to
//   idle. A refused request gets its result from the window check alone.
//   A run test checks the window, then walks the run bit by bit, reading
//   each map byte it enters once before walking its bits.
//   A result goes to an output register; while the receiver stalls, the
//   next request is still taken, and the block holds its next result until
//   the output register is free.
//   After reset the map is cleared one byte per cycle, with in_stall high;
//   configuration writes are taken during that time.
// ----------------------------------------------------------------------------
`default_nettype none

module range_checked_allocation_bitmap (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire rcab_pkg::in_item_t             in_item,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output rcab_pkg::out_item_t                 out_item,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [rcab_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [rcab_pkg::IDX_W-1:0]           cfg_data
);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_EVAL,
		ST_RMW,
		ST_RRD,
		ST_RCHK,
		ST_WAIT
	} state_t;

	state_t                          state_q, state_nx;
	logic [rcab_pkg::ADDR_W-1:0]     clr_q;
	logic [rcab_pkg::IDX_W-1:0]      first_q, last_q;
	logic [rcab_pkg::OFF_W-1:0]      limit_q;
	logic                            empty_q;
	rcab_pkg::mode_t                 mode_s1;
	logic [rcab_pkg::IDX_W-1:0]      d_s1;
	logic                            below_s1;
	logic [rcab_pkg::LEN_W-1:0]      rem_q;
	logic [rcab_pkg::OFF_W:0]        cur_q;
	logic                            out_valid_q;
	rcab_pkg::out_item_t             out_q, res_q;

	logic [rcab_pkg::IDX_W-1:0]      span;
	logic                            win_ok, cur_ok, out_free;
	logic                            fin;
	rcab_pkg::out_item_t             fin_res;
	logic                            walk_step;
	logic [7:0]                      mask;
	logic                            ram_we, ram_re;
	logic [rcab_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
	logic [7:0]                      ram_wdata, ram_rdata;

	rcab_ram #(
		.WIDTH (8),
		.DEPTH (rcab_pkg::MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign span      = last_q - first_q;
	assign win_ok    = !below_s1 && !empty_q
	                   && (d_s1[rcab_pkg::IDX_W-1:rcab_pkg::OFF_W] == '0)
	                   && (d_s1[rcab_pkg::OFF_W-1:0] <= limit_q);
	assign cur_ok    = cur_q <= {1'b0, limit_q};
	assign out_free  = !out_valid_q || !out_stall;
	assign mask      = 8'(1) << (d_s1[2:0] & rcab_pkg::BIT_IN_BYTE);
	assign in_stall  = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		state_nx  = state_q;
		fin       = 1'b0;
		fin_res   = '0;
		walk_step = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = d_s1[rcab_pkg::OFF_W-1:3];
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = d_s1[rcab_pkg::OFF_W-1:3];
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == rcab_pkg::ADDR_W'(rcab_pkg::MAP_BYTES - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (mode_s1 == rcab_pkg::MODE_RUN) begin
					if (rem_q == '0) begin
						fin            = 1'b1;
						fin_res.answer = 1'b1;
					end else if (!win_ok) begin
						fin                  = 1'b1;
						fin_res.out_of_range = 1'b1;
					end else begin
						state_nx = ST_RRD;
					end
				end else if (!win_ok) begin
					fin                  = 1'b1;
					fin_res.out_of_range = 1'b1;
				end else begin
					ram_re   = 1'b1;
					state_nx = ST_RMW;
				end
			end
			ST_RMW: begin
				fin = 1'b1;
				unique case (mode_s1)
					rcab_pkg::MODE_MARK: begin
						ram_we         = 1'b1;
						ram_wdata      = ram_rdata | mask;
						fin_res.answer = 1'b1;
					end
					rcab_pkg::MODE_UNMARK: begin
						ram_we         = 1'b1;
						ram_wdata      = ram_rdata & ~mask;
						fin_res.answer = 1'b1;
					end
					default: begin
						fin_res.answer = (ram_rdata & mask) != '0;
					end
				endcase
			end
			ST_RRD: begin
				ram_raddr = cur_q[rcab_pkg::OFF_W-1:3];
				if (!cur_ok) begin
					fin                  = 1'b1;
					fin_res.out_of_range = 1'b1;
				end else begin
					ram_re   = 1'b1;
					state_nx = ST_RCHK;
				end
			end
			ST_RCHK: begin
				if (!cur_ok) begin
					fin                  = 1'b1;
					fin_res.out_of_range = 1'b1;
				end else if (ram_rdata[cur_q[2:0]]) begin
					fin = 1'b1;
				end else if (rem_q == rcab_pkg::LEN_W'(1)) begin
					fin            = 1'b1;
					fin_res.answer = 1'b1;
				end else begin
					walk_step = 1'b1;
					if ((cur_q[2:0] & rcab_pkg::BIT_IN_BYTE) == rcab_pkg::BIT_IN_BYTE) begin
						state_nx = ST_RRD;
					end
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_nx = out_free ? ST_IDLE : ST_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			first_q     <= rcab_pkg::FIRST_RESET;
			last_q      <= rcab_pkg::LAST_RESET;
			limit_q     <= rcab_pkg::OFF_W'(rcab_pkg::MAP_BITS - 1);
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) begin
				unique case (cfg_index)
					rcab_pkg::CFG_FIRST_INDEX: first_q <= cfg_data;
					rcab_pkg::CFG_LAST_INDEX:  last_q  <= cfg_data;
					default: ;
				endcase
			end
			empty_q <= last_q < first_q;
			limit_q <= (span > rcab_pkg::LIMIT_MAX) ? rcab_pkg::LIMIT_MAX[rcab_pkg::OFF_W-1:0]
			                                        : span[rcab_pkg::OFF_W-1:0];
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (state_q == ST_WAIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item, walk and result registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mode_s1  <= in_item.mode;
			d_s1     <= in_item.object_number - first_q;
			below_s1 <= in_item.object_number < first_q;
			rem_q    <= in_item.run_length;
		end
		if (state_q == ST_EVAL) begin
			cur_q <= {1'b0, d_s1[rcab_pkg::OFF_W-1:0]};
		end
		if (walk_step) begin
			cur_q <= cur_q + 1'b1;
			rem_q <= rem_q - 1'b1;
		end
		if (fin && out_free) begin
			out_q <= fin_res;
		end else if (state_q == ST_WAIT && out_free) begin
			out_q <= res_q;
		end
		if (fin) begin
			res_q <= fin_res;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rcab_checker.sv
// ----------------------------------------------------------------------------
// rcab_checker
// Port-level checks of the range checked allocation bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module rcab_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       in_valid,
	input wire                       in_stall,
	input wire                       out_valid,
	input wire                       out_stall,
	input wire rcab_pkg::out_item_t  out_item
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// one request in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in work");

	// a result needs at least the window check cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && !in_stall))
		else $error("result shown right after accept");

endmodule

bind range_checked_allocation_bitmap rcab_checker u_rcab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire

>>> tb/sv/tb_range_checked_allocation_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_checked_allocation_bitmap
// Self-checking testbench of the range checked allocation bitmap. A local
// copy of the map and the window registers predicts the answer and the
// range flag of every request. Directed tests hit the window edges, the
// empty and the cut windows, runs past the map and past the top of the
// object number space. Then random traffic runs under a series of window
// settings, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------

module tb_range_checked_allocation_bitmap;

	import rcab_pkg::*;

	localparam int LIMIT_CYCLES  = 30000000;
	localparam int ITEMS_PER_SET = 92;
	localparam int DRAIN_CYCLES  = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_item = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [IDX_W-1:0]     cfg_data = '0;

	bit                   used_map [MAP_BITS];
	logic [IDX_W-1:0]     win_first = FIRST_RESET;
	logic [IDX_W-1:0]     win_last  = LAST_RESET;
	out_item_t            pending_results [$];

	int                   burst_left = 0;
	int                   error_count = 0;
	int                   cycle_count = 0;
	int                   item_count = 0;
	int                   result_count = 0;
	int                   refused_count = 0;
	int                   run_count = 0;
	int                   window_count = 0;

	int                   stall_tick = 0;
	int                   stall_hold = 0;
	bit                   stall_level = 1'b0;

	range_checked_allocation_bitmap uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic bit in_window(input logic [32:0] n, output int unsigned off);
		logic [32:0] lo;
		logic [32:0] hi;
		lo = {1'b0, win_first};
		hi = {1'b0, win_last};
		off = 0;
		if (n < lo || n > hi) return 1'b0;
		if (n - lo >= 33'(MAP_BITS)) return 1'b0;
		off = int'(n - lo);
		return 1'b1;
	endfunction

	function automatic out_item_t apply_request(input in_item_t req);
		out_item_t   res;
		int unsigned off;
		int unsigned i;
		res = '0;
		if (req.mode == MODE_RUN) begin
			res.answer = 1'b1;
			for (i = 0; i < int'(req.run_length); i++) begin
				if (!in_window({1'b0, req.object_number} + 33'(i), off)) begin
					res.answer = 1'b0;
					res.out_of_range = 1'b1;
					break;
				end
				if (used_map[off]) begin
					res.answer = 1'b0;
					break;
				end
			end
		end else if (!in_window({1'b0, req.object_number}, off)) begin
			res.out_of_range = 1'b1;
		end else if (req.mode == MODE_MARK) begin
			used_map[off] = 1'b1;
			res.answer = 1'b1;
		end else if (req.mode == MODE_UNMARK) begin
			used_map[off] = 1'b0;
			res.answer = 1'b1;
		end else begin
			res.answer = used_map[off];
		end
		return res;
	endfunction

	task automatic send_request(input mode_t m, input logic [IDX_W-1:0] obj,
			input logic [LEN_W-1:0] len);
		in_item_t req;
		int       gap;
		req.mode = m;
		req.object_number = obj;
		req.run_length = len;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_item = req;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_request(req));
		item_count++;
		if (m == MODE_RUN) run_count++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		wait (pending_results.size() == 0);
		@(negedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [IDX_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_FIRST_INDEX) win_first = value;
		else win_last = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_window(input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] last);
		wait_idle();
		cfg_write(CFG_FIRST_INDEX, first);
		cfg_write(CFG_LAST_INDEX, last);
		window_count++;
	endtask

	task automatic test_reset_window();
		send_request(MODE_MARK, 32'd0, '0);
		send_request(MODE_MARK, 32'd8191, '0);
		send_request(MODE_TEST, 32'd0, 14'h3FFF);
		send_request(MODE_TEST, 32'd8191, '0);
		send_request(MODE_TEST, 32'd1, '0);
		send_request(MODE_MARK, 32'd8192, '0);
		send_request(MODE_TEST, 32'hFFFF_FFFF, '0);
		send_request(MODE_UNMARK, 32'd8192, '0);
		send_request(MODE_RUN, 32'hFFFF_FFFF, 14'd0);
		send_request(MODE_RUN, 32'd1, 14'd5);
		send_request(MODE_RUN, 32'd8188, 14'd4);
		send_request(MODE_UNMARK, 32'd0, '0);
		send_request(MODE_TEST, 32'd0, '0);
		send_request(MODE_RUN, 32'd8191, 14'd2);
	endtask

	task automatic test_top_window();
		set_window(32'hFFFF_F000, 32'hFFFF_FFFF);
		send_request(MODE_RUN, 32'hFFFF_FFF0, 14'd20);
		send_request(MODE_MARK, 32'hFFFF_FFFF, '0);
		send_request(MODE_TEST, 32'hFFFF_EFFF, '0);
		send_request(MODE_UNMARK, 32'hFFFF_FFFF, '0);
		send_request(MODE_RUN, 32'hFFFF_F000, 14'h3FFF);
	endtask

	task automatic test_cut_window();
		set_window(32'd0, 32'hFFFF_FFFF);
		send_request(MODE_MARK, 32'd8192, '0);
		send_request(MODE_RUN, 32'd0, 14'd8192);
		send_request(MODE_UNMARK, 32'd8191, '0);
		send_request(MODE_RUN, 32'd0, 14'h3FFF);
	endtask

	task automatic test_empty_window();
		set_window(32'd500, 32'd100);
		send_request(MODE_MARK, 32'd300, '0);
		send_request(MODE_RUN, 32'd300, 14'd0);
		send_request(MODE_RUN, 32'd300, 14'd1);
	endtask

	task automatic test_random_traffic();
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] last;
		logic [IDX_W-1:0] obj;
		logic [LEN_W-1:0] len;
		logic [32:0]      span;
		logic [32:0]      hot;
		int               pick;
		for (int set_no = 0; set_no < 8; set_no++) begin
			first = $urandom;
			case (set_no)
				0: begin
					first = FIRST_RESET;
					last = LAST_RESET;
				end
				1: begin
					first = 32'd0;
					last = 32'd0;
				end
				2: begin
					first = 32'd0;
					last = 32'hFFFF_FFFF;
				end
				3: begin
					first = 32'hFFFF_FFFF;
					last = 32'hFFFF_FFFF;
				end
				4: begin
					first = 32'd1000;
					last = 32'd1063;
				end
				5: begin
					first = 32'hFFFF_FFC0;
					last = 32'hFFFF_FFFF;
				end
				6: last = first + $urandom_range(0, 300);
				default: last = $urandom;
			endcase
			set_window(first, last);
			if (last >= first) begin
				span = {1'b0, last} - {1'b0, first};
				if (span > 33'(MAP_BITS - 1)) span = 33'(MAP_BITS - 1);
			end else begin
				span = 33'd64;
			end
			hot = 33'($urandom_range(0, int'(span)));
			for (int k = 0; k < ITEMS_PER_SET; k++) begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					obj = first + 32'(hot) + $urandom_range(0, 47);
				else if (pick < 8)
					obj = first - 32'd2 + $urandom_range(0, int'(span) + 4);
				else
					obj = $urandom;
				pick = $urandom_range(0, 19);
				if (pick < 17)
					len = $urandom_range(0, 24);
				else if (pick < 19)
					len = $urandom_range(0, 300);
				else
					len = $urandom;
				send_request(mode_t'($urandom_range(0, 3)), obj, len);
			end
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			stall_tick <= stall_tick + 1;
			case ((stall_tick / 256) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 1);
				2: out_stall <= ((stall_tick % 7) < 3);
				default: begin
					if (stall_hold == 0) begin
						stall_level <= ~stall_level;
						stall_hold <= $urandom_range(1, 30);
						out_stall <= ~stall_level;
					end else begin
						stall_hold <= stall_hold - 1;
						out_stall <= stall_level;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		out_item_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request waiting: answer %0b out_of_range %0b",
					out_item.answer, out_item.out_of_range);
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				result_count++;
				if (exp_res.out_of_range) refused_count++;
				if (out_item.answer !== exp_res.answer) begin
					$error("answer: expected %0b, got %0b", exp_res.answer, out_item.answer);
					error_count++;
				end
				if (out_item.out_of_range !== exp_res.out_of_range) begin
					$error("out_of_range: expected %0b, got %0b",
						exp_res.out_of_range, out_item.out_of_range);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout with %0d results outstanding", pending_results.size());
			$display("range_checked_allocation_bitmap: mismatch");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAP_BITS; i++) used_map[i] = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_reset_window();
		test_top_window();
		test_cut_window();
		test_empty_window();
		test_random_traffic();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests (%0d run tests) over %0d window settings, %0d results",
			item_count, run_count, window_count, result_count);
		$display("%0d results flagged out of range, %0d cycles", refused_count, cycle_count);
		if (error_count == 0 && pending_results.size() == 0)
			$display("range_checked_allocation_bitmap: match");
		else
			$display("range_checked_allocation_bitmap: mismatch");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/rcab_pkg.sv
rtl/core/rcab_ram.sv
rtl/core/range_checked_allocation_bitmap.sv
rtl/core/rcab_checker.sv
tb/sv/tb_range_checked_allocation_bitmap.sv
